[hdl/wpt_pkg.sv]
// Package for the waypoint path tracker: request and result types,
// opcode, mode and register codes, fixed-point constants, CORDIC angle table.
// No dependencies.
`default_nettype none

package wpt_pkg;

  localparam int MAX_POINTS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CfgW = 31;
  localparam int CfgIdxW = 3;

  localparam logic [1:0] OP_POSE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_WAYPT = 2'd2;

  localparam logic [1:0] MODE_ROTATE = 2'd0;
  localparam logic [1:0] MODE_DRIVE  = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ROUTE_LEN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TURN_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TURN_LIM   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_GAIN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_LIM  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ALIGN_THR  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_ARRIVE_RAD = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_CROSS_GAIN = 3'd7;

  localparam logic [4:0]  RST_ROUTE_LEN  = 5'd1;
  localparam logic [15:0] RST_TURN_GAIN  = 16'd8192;
  localparam logic [14:0] RST_TURN_LIM   = 15'd20480;
  localparam logic [15:0] RST_SPEED_GAIN = 16'd2867;
  localparam logic [14:0] RST_SPEED_LIM  = 15'd4096;
  localparam logic [13:0] RST_ALIGN_THR  = 14'd910;
  localparam logic [30:0] RST_ARRIVE_RAD = 31'd3277;
  localparam logic [15:0] RST_CROSS_GAIN = 16'd8192;

  // 1/K for the CORDIC gain, Q0.16; 2*pi in Q3.13
  localparam logic [31:0] K_INV     = 32'd39797;
  localparam logic [31:0] TWO_PI_Q  = 32'd51472;

  typedef struct packed {
    logic [1:0]          opcode;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [15:0]  quat_w;
    logic signed [15:0]  quat_x;
    logic signed [15:0]  quat_y;
    logic signed [15:0]  quat_z;
    logic [3:0]          slot;
    logic signed [31:0]  goal_x;
    logic signed [31:0]  goal_y;
  } in_t;

  typedef struct packed {
    logic [14:0]         forward_speed;
    logic signed [15:0]  turn_rate;
    logic [1:0]          mode;
    logic [4:0]          target;
    logic                reached;
  } out_t;

  function automatic logic [31:0] atan_ang(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // round a 32-bit binary angle to 16 bits
  function automatic logic [15:0] to16(input logic [31:0] z);
    logic [31:0] s;
    s = z + 32'h0000_8000;
    return s[31:16];
  endfunction

endpackage

`default_nettype wire

[hdl/wpt_ram.sv]
// Generic single-port RAM with registered read, used for the waypoint table.
// No dependencies.
`default_nettype none

module wpt_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

[hdl/waypoint_path_tracker.sv]
// Waypoint path tracker top level: pose store, waypoint table, control tick.
// Depends on wpt_pkg and wpt_ram.
//
//  channel | direction | handshake              | payload
//  in      | request   | in_valid_i/in_ready_o   | wpt_pkg::in_t
//  out     | result    | out_valid_o/out_ready_i | wpt_pkg::out_t
//  cfg     | write     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One request at a time. Waypoint writes are done in the idle state; pose samples use
// the serial multiplier (one multiplier bit per cycle) and one-step-per-cycle CORDIC;
// ticks that give a result use these and the one-step-per-cycle square root as well.
// A finished result waits in the output register while the next request is taken.
// No clearing pass after reset; stalls on the output hold the sequencer in ST_OUT.
`default_nettype none

module waypoint_path_tracker #(
  parameter int MaxPoints   = wpt_pkg::MAX_POINTS_DEF,
  parameter int CordicSteps = wpt_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire wpt_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output wpt_pkg::out_t                      out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [wpt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [wpt_pkg::CfgW-1:0]      cfg_data_i
);

  import wpt_pkg::*;

  localparam int AW   = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int LenW = ($clog2(MaxPoints + 1) > 5) ? $clog2(MaxPoints + 1) : 5;
  localparam int CitW = $clog2(CordicSteps + 1);
  localparam int CW   = 44;
  localparam int MW   = 76;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PHASE  = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_CORDIC = 3'd3;
  localparam logic [2:0] ST_SQRT   = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  localparam logic [4:0] PH_P_QXY   = 5'd0;
  localparam logic [4:0] PH_P_QYY   = 5'd1;
  localparam logic [4:0] PH_P_QZZ   = 5'd2;
  localparam logic [4:0] PH_P_ANG   = 5'd3;
  localparam logic [4:0] PH_P_END   = 5'd4;
  localparam logic [4:0] PH_T_GOAL  = 5'd5;
  localparam logic [4:0] PH_T_PREV  = 5'd6;
  localparam logic [4:0] PH_T_SQY   = 5'd7;
  localparam logic [4:0] PH_T_SQRT  = 5'd8;
  localparam logic [4:0] PH_T_ROT   = 5'd9;
  localparam logic [4:0] PH_T_CROSS = 5'd10;
  localparam logic [4:0] PH_T_ARG   = 5'd11;
  localparam logic [4:0] PH_T_PHI   = 5'd12;
  localparam logic [4:0] PH_T_ERR   = 5'd13;
  localparam logic [4:0] PH_T_GAIN  = 5'd14;
  localparam logic [4:0] PH_T_TURN  = 5'd15;
  localparam logic [4:0] PH_T_SPEED = 5'd16;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // configuration
  logic [4:0]  route_len_q;
  logic [15:0] turn_gain_q, speed_gain_q, cross_gain_q;
  logic [14:0] turn_lim_q, speed_lim_q;
  logic [13:0] align_thr_q;
  logic [30:0] arrive_rad_q;

  // sequencer and state
  logic [2:0] state_q, state_d;
  logic [4:0] phase_q, phase_d;
  logic signed [31:0] robot_x_q, robot_x_d, robot_y_q, robot_y_d;
  logic signed [31:0] origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic [15:0] heading_q, heading_d, origin_head_q, origin_head_d;
  logic have_origin_q, have_origin_d;
  logic [1:0] mode_q, mode_d;
  logic [4:0] target_q, target_d;

  // operands
  logic signed [15:0] qx_q, qx_d, qy_q, qy_d, qz_q, qz_d;
  logic signed [33:0] t0_q, t0_d, t1_q, t1_d;
  logic signed [31:0] gx_q, gx_d, gy_q, gy_d;
  logic signed [32:0] lx_q, lx_d, ly_q, ly_d;
  logic [31:0] oy_mag_q, oy_mag_d;
  logic [63:0] n_q, n_d, r_q, r_d, bit_q, bit_d;
  logic [31:0] dist_q, dist_d, theta_q, theta_d;
  logic ex_pos_q, ex_pos_d;
  logic [16:0] aerr_q, aerr_d;
  logic err_neg_q, err_neg_d;

  // serial multiplier
  logic [MW-1:0] ma_q, ma_d, macc_q, macc_d;
  logic [31:0] mb_q, mb_d;
  logic mneg_q, mneg_d;
  logic signed [MW:0] prod_s;

  // CORDIC
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d, cu_q, cu_d, cv_q, cv_d;
  logic [31:0] cz_q, cz_d;
  logic [CitW-1:0] cit_q, cit_d;

  out_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  // scratch
  logic mul_go, cor_ld;
  logic [MW-1:0] mul_a;
  logic [31:0] mul_b;
  logic mul_n;
  logic signed [CW-1:0] cor_x, cor_y, cor_u, cor_v;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0] ram_rdata;
  logic [LenW-1:0] len_eff;
  logic signed [33:0] qsum;
  logic signed [31:0] prx, pry;
  logic signed [32:0] px, py;
  logic signed [34:0] dx, dy;
  logic [34:0] dx_mag, dy_mag;
  logic [31:0] ox_mag;
  logic signed [MW:0] sh_s;
  logic signed [CW-1:0] cross_err;
  logic [15:0] e16;
  logic [MW-1:0] rnd;
  logic [14:0] mag15, spd15;
  logic [4:0] tgt_n;
  logic [1:0] new_mode;
  logic sqrt_ge;

  assign len_eff = (route_len_q == 5'd0) ? LenW'(1) :
                   ((LenW'(route_len_q) > LenW'(MaxPoints)) ? LenW'(MaxPoints) :
                    LenW'(route_len_q));
  assign prod_s  = mneg_q ? -$signed({1'b0, macc_q}) : $signed({1'b0, macc_q});
  assign sqrt_ge = n_q >= (r_q + bit_q);

  wpt_ram #(
    .Width(64),
    .Depth(MaxPoints)
  ) u_route (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i({in_data_i.goal_x, in_data_i.goal_y}),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;  phase_d = phase_q;
    robot_x_d = robot_x_q;  robot_y_d = robot_y_q;
    origin_x_d = origin_x_q;  origin_y_d = origin_y_q;
    heading_d = heading_q;  origin_head_d = origin_head_q;
    have_origin_d = have_origin_q;  mode_d = mode_q;  target_d = target_q;
    qx_d = qx_q;  qy_d = qy_q;  qz_d = qz_q;  t0_d = t0_q;  t1_d = t1_q;
    gx_d = gx_q;  gy_d = gy_q;  lx_d = lx_q;  ly_d = ly_q;  oy_mag_d = oy_mag_q;
    n_d = n_q;  r_d = r_q;  bit_d = bit_q;  dist_d = dist_q;  theta_d = theta_q;
    ex_pos_d = ex_pos_q;  aerr_d = aerr_q;  err_neg_d = err_neg_q;
    ma_d = ma_q;  mb_d = mb_q;  macc_d = macc_q;  mneg_d = mneg_q;
    cx_d = cx_q;  cy_d = cy_q;  cu_d = cu_q;  cv_d = cv_q;  cz_d = cz_q;  cit_d = cit_q;
    res_d = res_q;  out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    mul_go = 1'b0;  mul_a = '0;  mul_b = '0;  mul_n = 1'b0;
    cor_ld = 1'b0;  cor_x = '0;  cor_y = '0;  cor_u = '0;  cor_v = '0;
    ram_we = 1'b0;  ram_addr = AW'(target_q);
    qsum = '0;  prx = '0;  pry = '0;  px = '0;  py = '0;  dx = '0;  dy = '0;
    dx_mag = '0;  dy_mag = '0;  ox_mag = '0;  sh_s = '0;  cross_err = '0;  e16 = '0;
    rnd = '0;  mag15 = '0;  spd15 = '0;  tgt_n = '0;  new_mode = mode_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.opcode)
            OP_POSE: begin
              robot_x_d = in_data_i.pos_x;
              robot_y_d = in_data_i.pos_y;
              if (!have_origin_q) begin
                origin_x_d = in_data_i.pos_x;
                origin_y_d = in_data_i.pos_y;
              end
              qx_d = in_data_i.quat_x;
              qy_d = in_data_i.quat_y;
              qz_d = in_data_i.quat_z;
              mul_go = 1'b1;
              mul_a = MW'(mag(CW'(in_data_i.quat_w)));
              mul_b = 32'(mag(CW'(in_data_i.quat_z)));
              mul_n = in_data_i.quat_w[15] ^ in_data_i.quat_z[15];
              phase_d = PH_P_QXY;
            end
            OP_WAYPT: begin
              ram_addr = AW'(in_data_i.slot);
              ram_we = LenW'(in_data_i.slot) < LenW'(MaxPoints);
            end
            OP_TICK: begin
              if (have_origin_q && mode_q != MODE_FINISH) begin
                if (LenW'(target_q) >= len_eff) begin
                  mode_d = MODE_FINISH;
                end else begin
                  state_d = ST_PHASE;
                  phase_d = PH_T_GOAL;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_MUL: begin
        if (mb_q == 32'd0) begin
          state_d = ST_PHASE;
        end else begin
          if (mb_q[0]) macc_d = macc_q + ma_q;
          ma_d = ma_q << 1;
          mb_d = mb_q >> 1;
        end
      end

      ST_CORDIC: begin
        if (cit_q == CitW'(CordicSteps)) begin
          state_d = ST_PHASE;
        end else begin
          if (!cy_q[CW-1]) begin
            cx_d = cx_q + (cy_q >>> cit_q);
            cy_d = cy_q - (cx_q >>> cit_q);
            cu_d = cu_q + (cv_q >>> cit_q);
            cv_d = cv_q - (cu_q >>> cit_q);
            cz_d = cz_q + atan_ang(5'(cit_q));
          end else begin
            cx_d = cx_q - (cy_q >>> cit_q);
            cy_d = cy_q + (cx_q >>> cit_q);
            cu_d = cu_q - (cv_q >>> cit_q);
            cv_d = cv_q + (cu_q >>> cit_q);
            cz_d = cz_q - atan_ang(5'(cit_q));
          end
          cit_d = cit_q + CitW'(1);
        end
      end

      ST_SQRT: begin
        if (bit_q == 64'd0) begin
          state_d = ST_PHASE;
        end else begin
          if (sqrt_ge) begin
            n_d = n_q - (r_q + bit_q);
            r_d = (r_q >> 1) + bit_q;
          end else begin
            r_d = r_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d = res_q;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_PHASE: begin
        case (phase_q)
          PH_P_QXY: begin
            t0_d = 34'(prod_s);
            mul_go = 1'b1;
            mul_a = MW'(mag(CW'(qx_q)));
            mul_b = 32'(mag(CW'(qy_q)));
            mul_n = qx_q[15] ^ qy_q[15];
            phase_d = PH_P_QYY;
          end
          PH_P_QYY: begin
            t0_d = t0_q + 34'(prod_s);
            mul_go = 1'b1;
            mul_a = MW'(mag(CW'(qy_q)));
            mul_b = 32'(mag(CW'(qy_q)));
            phase_d = PH_P_QZZ;
          end
          PH_P_QZZ: begin
            t1_d = 34'(prod_s);
            mul_go = 1'b1;
            mul_a = MW'(mag(CW'(qz_q)));
            mul_b = 32'(mag(CW'(qz_q)));
            phase_d = PH_P_ANG;
          end
          PH_P_ANG: begin
            qsum = t1_q + 34'(prod_s);
            cor_ld = 1'b1;
            cor_x = (CW'(1) <<< 28) - (CW'(qsum) <<< 1);
            cor_y = CW'(t0_q) <<< 1;
            state_d = ST_CORDIC;
            phase_d = PH_P_END;
          end
          PH_P_END: begin
            heading_d = to16(cz_q);
            if (!have_origin_q) begin
              origin_head_d = to16(cz_q);
              have_origin_d = 1'b1;
            end
            state_d = ST_IDLE;
          end
          PH_T_GOAL: begin
            gx_d = ram_rdata[63:32];
            gy_d = ram_rdata[31:0];
            lx_d = 33'(robot_x_q) - 33'(origin_x_q);
            ly_d = 33'(robot_y_q) - 33'(origin_y_q);
            ram_addr = AW'(target_q - 5'd1);
            phase_d = PH_T_PREV;
          end
          PH_T_PREV: begin
            if (target_q != 5'd0) begin
              prx = ram_rdata[63:32];
              pry = ram_rdata[31:0];
            end
            px = 33'(gx_q) - 33'(prx);
            py = 33'(gy_q) - 33'(pry);
            if (px == 33'sd0 && py == 33'sd0) begin
              state_d = ST_IDLE;
            end else begin
              dx = 35'(gx_q) - 35'(lx_q);
              dy = 35'(gy_q) - 35'(ly_q);
              dx_mag = dx[34] ? 35'(-dx) : 35'(dx);
              dy_mag = dy[34] ? 35'(-dy) : 35'(dy);
              ox_mag = (dx_mag > 35'h0_8000_0000) ? 32'h8000_0000 : dx_mag[31:0];
              oy_mag_d = (dy_mag > 35'h0_8000_0000) ? 32'h8000_0000 : dy_mag[31:0];
              cor_ld = 1'b1;
              cor_x = CW'(px);
              cor_y = CW'(py);
              cor_u = -CW'(dx);
              cor_v = -CW'(dy);
              mul_go = 1'b1;
              mul_a = MW'(ox_mag);
              mul_b = ox_mag;
              phase_d = PH_T_SQY;
            end
          end
          PH_T_SQY: begin
            n_d = macc_q[63:0];
            mul_go = 1'b1;
            mul_a = MW'(oy_mag_q);
            mul_b = oy_mag_q;
            phase_d = PH_T_SQRT;
          end
          PH_T_SQRT: begin
            n_d = n_q + macc_q[63:0];
            r_d = '0;
            bit_d = 64'h4000_0000_0000_0000;
            state_d = ST_SQRT;
            phase_d = PH_T_ROT;
          end
          PH_T_ROT: begin
            dist_d = r_q[31:0];
            state_d = ST_CORDIC;
            phase_d = PH_T_CROSS;
          end
          PH_T_CROSS: begin
            theta_d = cz_q;
            ex_pos_d = !cu_q[CW-1];
            mul_go = 1'b1;
            mul_a = MW'(mag(cv_q));
            mul_b = K_INV;
            mul_n = cv_q[CW-1];
            phase_d = PH_T_ARG;
          end
          PH_T_ARG: begin
            sh_s = prod_s >>> 16;
            cross_err = CW'(sh_s);
            mul_go = 1'b1;
            mul_a = MW'(mag(cross_err));
            mul_b = 32'(cross_gain_q);
            mul_n = cross_err[CW-1];
            phase_d = PH_T_PHI;
          end
          PH_T_PHI: begin
            sh_s = prod_s >>> 12;
            cor_ld = 1'b1;
            cor_x = CW'(65536);
            cor_y = CW'(sh_s);
            state_d = ST_CORDIC;
            phase_d = PH_T_ERR;
          end
          PH_T_ERR: begin
            e16 = to16(theta_q - cz_q) - (heading_q - origin_head_q);
            err_neg_d = e16[15];
            aerr_d = e16[15] ? (17'h1_0000 - {1'b0, e16}) : {1'b0, e16};
            mul_go = 1'b1;
            if (mode_q == MODE_ROTATE) begin
              mul_a = MW'(e16[15] ? (17'h1_0000 - {1'b0, e16}) : {1'b0, e16});
              mul_b = 32'(turn_gain_q);
              phase_d = PH_T_GAIN;
            end else begin
              mul_a = MW'(dist_q);
              mul_b = 32'(speed_gain_q);
              phase_d = PH_T_SPEED;
            end
          end
          PH_T_GAIN: begin
            mul_go = 1'b1;
            mul_a = MW'(macc_q[31:0]);
            mul_b = TWO_PI_Q;
            phase_d = PH_T_TURN;
          end
          PH_T_TURN: begin
            rnd = (macc_q + (MW'(1) << 28)) >> 29;
            mag15 = (rnd > MW'(turn_lim_q)) ? turn_lim_q : rnd[14:0];
            if (aerr_q < 17'(align_thr_q)) new_mode = MODE_DRIVE;
            mode_d = new_mode;
            res_d.forward_speed = '0;
            res_d.turn_rate = err_neg_q ? -$signed({1'b0, mag15}) : $signed({1'b0, mag15});
            res_d.mode = new_mode;
            res_d.target = target_q;
            res_d.reached = 1'b0;
            state_d = ST_OUT;
          end
          PH_T_SPEED: begin
            spd15 = (macc_q[MW-1:16] > (MW-16)'(speed_lim_q)) ? speed_lim_q :
                    macc_q[30:16];
            tgt_n = target_q;
            res_d.reached = 1'b0;
            if (ex_pos_q || (dist_q < {1'b0, arrive_rad_q})) begin
              res_d.reached = 1'b1;
              tgt_n = target_q + 5'd1;
              if (LenW'(tgt_n) >= len_eff) begin
                new_mode = MODE_FINISH;
                spd15 = '0;
              end else begin
                new_mode = MODE_ROTATE;
              end
            end
            target_d = tgt_n;
            mode_d = new_mode;
            res_d.forward_speed = spd15;
            res_d.turn_rate = '0;
            res_d.mode = new_mode;
            res_d.target = tgt_n;
            state_d = ST_OUT;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      default: state_d = ST_IDLE;
    endcase

    if (mul_go) begin
      ma_d = mul_a;
      mb_d = mul_b;
      macc_d = '0;
      mneg_d = mul_n;
      state_d = ST_MUL;
    end

    if (cor_ld) begin
      if (cor_x == '0 && cor_y == '0) begin
        cx_d = cor_x;  cy_d = cor_y;  cu_d = cor_u;  cv_d = cor_v;
        cz_d = '0;
        cit_d = CitW'(CordicSteps);
      end else if (cor_x[CW-1]) begin
        cx_d = -cor_x;  cy_d = -cor_y;  cu_d = -cor_u;  cv_d = -cor_v;
        cz_d = 32'h8000_0000;
        cit_d = '0;
      end else begin
        cx_d = cor_x;  cy_d = cor_y;  cu_d = cor_u;  cv_d = cor_v;
        cz_d = '0;
        cit_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_len_q  <= RST_ROUTE_LEN;
      turn_gain_q  <= RST_TURN_GAIN;
      turn_lim_q   <= RST_TURN_LIM;
      speed_gain_q <= RST_SPEED_GAIN;
      speed_lim_q  <= RST_SPEED_LIM;
      align_thr_q  <= RST_ALIGN_THR;
      arrive_rad_q <= RST_ARRIVE_RAD;
      cross_gain_q <= RST_CROSS_GAIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROUTE_LEN:  route_len_q  <= cfg_data_i[4:0];
        CFG_TURN_GAIN:  turn_gain_q  <= cfg_data_i[15:0];
        CFG_TURN_LIM:   turn_lim_q   <= cfg_data_i[14:0];
        CFG_SPEED_GAIN: speed_gain_q <= cfg_data_i[15:0];
        CFG_SPEED_LIM:  speed_lim_q  <= cfg_data_i[14:0];
        CFG_ALIGN_THR:  align_thr_q  <= cfg_data_i[13:0];
        CFG_ARRIVE_RAD: arrive_rad_q <= cfg_data_i[30:0];
        CFG_CROSS_GAIN: cross_gain_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_P_QXY;
      robot_x_q     <= '0;
      robot_y_q     <= '0;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      heading_q     <= '0;
      origin_head_q <= '0;
      have_origin_q <= 1'b0;
      mode_q        <= MODE_ROTATE;
      target_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      robot_x_q     <= robot_x_d;
      robot_y_q     <= robot_y_d;
      origin_x_q    <= origin_x_d;
      origin_y_q    <= origin_y_d;
      heading_q     <= heading_d;
      origin_head_q <= origin_head_d;
      have_origin_q <= have_origin_d;
      mode_q        <= mode_d;
      target_q      <= target_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= qx_d;  qy_q <= qy_d;  qz_q <= qz_d;
    t0_q <= t0_d;  t1_q <= t1_d;
    gx_q <= gx_d;  gy_q <= gy_d;  lx_q <= lx_d;  ly_q <= ly_d;
    oy_mag_q <= oy_mag_d;
    n_q <= n_d;  r_q <= r_d;  bit_q <= bit_d;
    dist_q <= dist_d;  theta_q <= theta_d;  ex_pos_q <= ex_pos_d;
    aerr_q <= aerr_d;  err_neg_q <= err_neg_d;
    ma_q <= ma_d;  mb_q <= mb_d;  macc_q <= macc_d;  mneg_q <= mneg_d;
    cx_q <= cx_d;  cy_q <= cy_d;  cu_q <= cu_d;  cv_q <= cv_d;
    cz_q <= cz_d;  cit_q <= cit_d;
    res_q <= res_d;  out_q <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.forward_speed == '0 || out_data_o.turn_rate == '0))
    else $error("speed and turn both non-zero");

  a_reach_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reached |-> out_data_o.mode != MODE_DRIVE)
    else $error("reached waypoint left in drive mode");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output state");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != 2'd3)
    else $error("track mode corrupted");

endmodule

`default_nettype wire
